/* src/ufrc_pkg.sv */
// ----------------------------------------------------------------------------
// ufrc_pkg
// Shared types, codes and microcode table of the union-find engine.
// ----------------------------------------------------------------------------
package ufrc_pkg;

    localparam int NODE_W  = 7;
    localparam int RANK_W  = 3;
    localparam int REQ_W   = 2;
    localparam int STEP_W  = 4;

    localparam logic [REQ_W-1:0]  REQ_CLEAR = 2'd0;
    localparam logic [REQ_W-1:0]  REQ_MERGE = 2'd1;
    localparam logic [REQ_W-1:0]  REQ_CHECK = 2'd2;
    // spare code, handled as a check
    localparam logic [REQ_W-1:0]  REQ_SPARE = 2'd3;
    localparam logic [RANK_W-1:0] RANK_MAX  = 3'd7;

    typedef logic [STEP_W-1:0] step_t;

    // microcode step addresses
    localparam step_t STEP_IDLE   = 4'd0;
    localparam step_t STEP_FA_RD  = 4'd1;
    localparam step_t STEP_FA_EV  = 4'd2;
    localparam step_t STEP_CA_CK  = 4'd3;
    localparam step_t STEP_CA_EV  = 4'd4;
    localparam step_t STEP_LOAD_B = 4'd5;
    localparam step_t STEP_FB_RD  = 4'd6;
    localparam step_t STEP_FB_EV  = 4'd7;
    localparam step_t STEP_CB_CK  = 4'd8;
    localparam step_t STEP_CB_EV  = 4'd9;
    localparam step_t STEP_LINK   = 4'd10;
    localparam step_t STEP_BUMP   = 4'd11;
    localparam step_t STEP_SWEEP  = 4'd12;
    localparam step_t STEP_SW_END = 4'd13;
    localparam step_t STEP_OUT    = 4'd14;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_FIND,
        OP_COMPRESS,
        OP_LOAD_B,
        OP_LINK,
        OP_BUMP,
        OP_SWEEP,
        OP_SWEEP_END,
        OP_OUT
    } op_t;

    typedef enum logic [3:0] {
        COND_NEXT,
        COND_ALWAYS,
        COND_IDLE,
        COND_NOT_ROOT,
        COND_AT_ROOT,
        COND_NO_BUMP,
        COND_SWEEP_MORE,
        COND_INIT,
        COND_OUT_FREE
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        logic  side;    // 0 works on node a, 1 on node b
        step_t target;
    } ctrl_t;

    typedef struct packed {
        logic accept;
        logic clear_req;
        logic is_root;
        logic at_root;
        logic no_bump;
        logic sweep_more;
        logic init;
        logic out_free;
    } status_t;

    function automatic ctrl_t ucode_rom(input step_t step);
        ctrl_t w;
        w = '{op: OP_NONE, cond: COND_ALWAYS, side: 1'b0, target: STEP_IDLE};
        unique case (step)
            STEP_IDLE:   w = '{OP_ACCEPT,    COND_IDLE,       1'b0, STEP_SWEEP};
            STEP_FA_RD:  w = '{OP_NONE,      COND_NEXT,       1'b0, STEP_IDLE};
            STEP_FA_EV:  w = '{OP_FIND,      COND_NOT_ROOT,   1'b0, STEP_FA_RD};
            STEP_CA_CK:  w = '{OP_NONE,      COND_AT_ROOT,    1'b0, STEP_LOAD_B};
            STEP_CA_EV:  w = '{OP_COMPRESS,  COND_NOT_ROOT,   1'b0, STEP_CA_CK};
            STEP_LOAD_B: w = '{OP_LOAD_B,    COND_NEXT,       1'b1, STEP_IDLE};
            STEP_FB_RD:  w = '{OP_NONE,      COND_NEXT,       1'b1, STEP_IDLE};
            STEP_FB_EV:  w = '{OP_FIND,      COND_NOT_ROOT,   1'b1, STEP_FB_RD};
            STEP_CB_CK:  w = '{OP_NONE,      COND_AT_ROOT,    1'b1, STEP_LINK};
            STEP_CB_EV:  w = '{OP_COMPRESS,  COND_NOT_ROOT,   1'b1, STEP_CB_CK};
            STEP_LINK:   w = '{OP_LINK,      COND_NO_BUMP,    1'b0, STEP_OUT};
            STEP_BUMP:   w = '{OP_BUMP,      COND_ALWAYS,     1'b1, STEP_OUT};
            STEP_SWEEP:  w = '{OP_SWEEP,     COND_SWEEP_MORE, 1'b0, STEP_SWEEP};
            STEP_SW_END: w = '{OP_SWEEP_END, COND_INIT,       1'b0, STEP_IDLE};
            STEP_OUT:    w = '{OP_OUT,       COND_OUT_FREE,   1'b0, STEP_IDLE};
            default:     w = '{OP_NONE,      COND_ALWAYS,     1'b0, STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

/* src/union_find_rank_compress_core.sv */
// ----------------------------------------------------------------------------
// union_find_rank_compress_core
// Disjoint-set engine with union by rank and full path compression. Every
// transaction on the s_ channel is a clear, a merge or a connectivity check on
// two nodes, and gives exactly one transaction on the m_ channel. Node
// indices fold into range modulo NODES. A microcoded sequencer drives a
// datapath around a single node memory with one read and one write port, so
// each hop of a find takes an address step and then a step on the registered
// read data. A merge or check walks the paths from node_a and node_b to their
// roots, following each link and then going back over it to compress it, and
// a tie adds a step that bumps a rank. A clear sweeps the memory one node per
// cycle; the same clearing pass runs after reset, and s_ready first rises
// when it ends. The result register lets a finished result wait while the
// engine returns to idle.
// ----------------------------------------------------------------------------
module union_find_rank_compress_core
    import ufrc_pkg::*;
#(
    parameter int NODES = 128
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [REQ_W-1:0]  s_req_type,
    input  logic [NODE_W-1:0] s_node_a,
    input  logic [NODE_W-1:0] s_node_b,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_same_set,
    output logic [NODE_W-1:0] m_root_of_a
);

    // control word from the microcode table, flags back from the datapath
    ctrl_t   ctrl;
    status_t status;

    // step counter and program table
    ufrc_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    // node memory, find and link registers, result register
    ufrc_datapath #(
        .NODES (NODES)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (ctrl),
        .status      (status),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_node_a    (s_node_a),
        .s_node_b    (s_node_b),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_same_set  (m_same_set),
        .m_root_of_a (m_root_of_a)
    );

    // no transaction taken while the reset clearing pass still runs
    a_no_accept_in_init: assert property (@(posedge aclk) disable iff (!aresetn)
        status.init |-> !s_ready)
        else $error("input taken during reset clearing pass");

    // a clear transaction goes straight into the sweep
    a_clear_sweeps: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_req_type == REQ_CLEAR) |=> ctrl.op == OP_SWEEP)
        else $error("clear did not start the sweep");

    // a rank bump only follows the link of a merge
    a_bump_after_link: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.op == OP_BUMP) |-> ($past(ctrl.op) == OP_LINK))
        else $error("rank bump without a preceding link");

endmodule

/* src/ufrc_sequencer.sv */
// ----------------------------------------------------------------------------
// ufrc_sequencer
// Step counter and microcode table with conditional jumps.
// ----------------------------------------------------------------------------
module ufrc_sequencer
    import ufrc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  status_t status,
    output ctrl_t   ctrl
);

    step_t pc_reg;
    step_t pc_next;
    logic  taken;
    logic  hold;

    assign ctrl = ucode_rom(pc_reg);

    always_comb begin
        taken = 1'b0;
        hold  = 1'b0;
        unique case (ctrl.cond)
            COND_NEXT:       taken = 1'b0;
            COND_ALWAYS:     taken = 1'b1;
            COND_IDLE: begin
                taken = status.accept && status.clear_req;
                hold  = !status.accept;
            end
            COND_NOT_ROOT:   taken = !status.is_root;
            COND_AT_ROOT:    taken = status.at_root;
            COND_NO_BUMP:    taken = status.no_bump;
            COND_SWEEP_MORE: taken = status.sweep_more;
            COND_INIT:       taken = status.init;
            COND_OUT_FREE: begin
                taken = status.out_free;
                hold  = !status.out_free;
            end
            default:         taken = 1'b1;
        endcase
        priority if (taken) begin
            pc_next = ctrl.target;
        end else if (hold) begin
            pc_next = pc_reg;
        end else begin
            pc_next = pc_reg + step_t'(1);
        end
    end

    // reset starts in the clearing pass
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= STEP_SWEEP;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

/* src/ufrc_datapath.sv */
// ----------------------------------------------------------------------------
// ufrc_datapath
// Node memory, working registers and result register of the engine.
// ----------------------------------------------------------------------------
module ufrc_datapath
    import ufrc_pkg::*;
#(
    parameter int NODES = 128
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  ctrl_t             ctrl,
    output status_t           status,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [REQ_W-1:0]  s_req_type,
    input  logic [NODE_W-1:0] s_node_a,
    input  logic [NODE_W-1:0] s_node_b,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_same_set,
    output logic [NODE_W-1:0] m_root_of_a
);

    localparam int IDX_W  = $clog2(NODES);
    localparam int WORD_W = 1 + RANK_W + IDX_W;
    localparam int IN_CNT = 1 << NODE_W;
    localparam int FOLD_W = IN_CNT * IDX_W;
    localparam int OUT_W  = (IDX_W > NODE_W) ? IDX_W : NODE_W;

    // input index folded into range, worked out at elaboration
    function automatic logic [FOLD_W-1:0] build_fold();
        logic [FOLD_W-1:0] tab;
        int                v;
        tab = '0;
        for (int i = 0; i < IN_CNT; i++) begin
            v = i % NODES;
            tab[i*IDX_W +: IDX_W] = v[IDX_W-1:0];
        end
        return tab;
    endfunction

    localparam logic [FOLD_W-1:0] FOLD_TAB = build_fold();

    // node word: is_root, rank, parent
    logic [WORD_W-1:0] node_mem [NODES];
    logic [WORD_W-1:0] rdata_reg;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [WORD_W-1:0] wr_data;

    logic [IDX_W-1:0]  na_reg, na_next, nb_reg, nb_next;
    logic [IDX_W-1:0]  cur_reg, cur_next;
    logic [IDX_W-1:0]  ra_reg, ra_next, rb_reg, rb_next;
    logic [RANK_W-1:0] rka_reg, rka_next, rkb_reg, rkb_next;
    logic [IDX_W-1:0]  res_reg, res_next;
    logic              same_reg, same_next;
    logic [REQ_W-1:0]  kind_reg, kind_next;
    logic [IDX_W-1:0]  sweep_cnt_reg, sweep_cnt_next;
    logic              init_reg, init_next;
    logic              m_valid_reg, m_valid_next;
    logic              m_same_reg, m_same_next;
    logic [IDX_W-1:0]  m_root_reg, m_root_next;
    logic [OUT_W-1:0]  m_root_wide;

    logic              rd_is_root;
    logic [RANK_W-1:0] rd_rank;
    logic [IDX_W-1:0]  rd_parent;
    logic [IDX_W-1:0]  fold_a, fold_b;
    logic [IDX_W-1:0]  side_root;
    logic              accept;
    logic              out_free;
    logic              merging;
    logic [RANK_W-1:0] rank_up;

    assign rd_is_root = rdata_reg[WORD_W-1];
    assign rd_rank    = rdata_reg[WORD_W-2 -: RANK_W];
    assign rd_parent  = rdata_reg[IDX_W-1:0];

    assign fold_a = FOLD_TAB[int'(s_node_a)*IDX_W +: IDX_W];
    assign fold_b = FOLD_TAB[int'(s_node_b)*IDX_W +: IDX_W];

    assign s_ready   = (ctrl.op == OP_ACCEPT);
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign side_root = ctrl.side ? rb_reg : ra_reg;
    assign merging   = (kind_reg == REQ_MERGE) && (ra_reg != rb_reg);
    assign rank_up   = (rkb_reg == RANK_MAX) ? rkb_reg : rkb_reg + RANK_W'(1);

    assign status.accept     = accept;
    assign status.clear_req  = (s_req_type == REQ_CLEAR);
    assign status.is_root    = rd_is_root;
    assign status.at_root    = (cur_reg == side_root);
    assign status.no_bump    = !merging || (rka_reg != rkb_reg);
    assign status.sweep_more = (sweep_cnt_reg != IDX_W'(NODES - 1));
    assign status.init       = init_reg;
    assign status.out_free   = out_free;

    assign m_valid     = m_valid_reg;
    assign m_same_set  = m_same_reg;
    assign m_root_wide = OUT_W'(m_root_reg);
    assign m_root_of_a = m_root_wide[NODE_W-1:0];

    always_comb begin
        na_next        = na_reg;
        nb_next        = nb_reg;
        cur_next       = cur_reg;
        ra_next        = ra_reg;
        rb_next        = rb_reg;
        rka_next       = rka_reg;
        rkb_next       = rkb_reg;
        res_next       = res_reg;
        same_next      = same_reg;
        kind_next      = kind_reg;
        sweep_cnt_next = sweep_cnt_reg;
        init_next      = init_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_same_next    = m_same_reg;
        m_root_next    = m_root_reg;
        wr_en          = 1'b0;
        wr_addr        = cur_reg;
        wr_data        = {1'b0, rd_rank, side_root};

        unique case (ctrl.op)
            OP_ACCEPT: begin
                if (accept) begin
                    na_next   = fold_a;
                    nb_next   = fold_b;
                    cur_next  = fold_a;
                    kind_next = s_req_type;
                    res_next  = '0;
                    same_next = 1'b0;
                end
            end
            OP_FIND: begin
                if (rd_is_root) begin
                    if (ctrl.side) begin
                        rb_next  = cur_reg;
                        rkb_next = rd_rank;
                        cur_next = nb_reg;
                    end else begin
                        ra_next  = cur_reg;
                        rka_next = rd_rank;
                        cur_next = na_reg;
                    end
                end else begin
                    cur_next = rd_parent;
                end
            end
            OP_COMPRESS: begin
                // relink a node on the path straight to the root
                if (!rd_is_root) begin
                    wr_en    = 1'b1;
                    cur_next = rd_parent;
                end
            end
            OP_LOAD_B: begin
                cur_next = nb_reg;
            end
            OP_LINK: begin
                same_next = (ra_reg == rb_reg);
                res_next  = ra_reg;
                if (merging) begin
                    wr_en = 1'b1;
                    if (rkb_reg < rka_reg) begin
                        wr_addr = rb_reg;
                        wr_data = {1'b0, rkb_reg, ra_reg};
                    end else begin
                        wr_addr  = ra_reg;
                        wr_data  = {1'b0, rka_reg, rb_reg};
                        res_next = rb_reg;
                    end
                end
            end
            OP_BUMP: begin
                wr_en   = 1'b1;
                wr_addr = rb_reg;
                wr_data = {1'b1, rank_up, rb_reg};
            end
            OP_SWEEP: begin
                wr_en          = 1'b1;
                wr_addr        = sweep_cnt_reg;
                wr_data        = {1'b1, {RANK_W{1'b0}}, {IDX_W{1'b0}}};
                sweep_cnt_next = status.sweep_more ? sweep_cnt_reg + IDX_W'(1) : '0;
            end
            OP_SWEEP_END: begin
                init_next = 1'b0;
            end
            OP_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_same_next  = same_reg;
                    m_root_next  = res_reg;
                end
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            node_mem[wr_addr] <= wr_data;
        end
        rdata_reg <= node_mem[cur_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_cnt_reg <= '0;
            init_reg      <= 1'b1;
            m_valid_reg   <= 1'b0;
        end else begin
            sweep_cnt_reg <= sweep_cnt_next;
            init_reg      <= init_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        na_reg     <= na_next;
        nb_reg     <= nb_next;
        cur_reg    <= cur_next;
        ra_reg     <= ra_next;
        rb_reg     <= rb_next;
        rka_reg    <= rka_next;
        rkb_reg    <= rkb_next;
        res_reg    <= res_next;
        same_reg   <= same_next;
        kind_reg   <= kind_next;
        m_same_reg <= m_same_next;
        m_root_reg <= m_root_next;
    end

endmodule

/* sim/union_find_rank_compress_checker.sv */
// ----------------------------------------------------------------------------
// union_find_rank_compress_checker
// Watches both channels of the union-find engine. Keeps its own disjoint-set
// forest (root flags, parent links, ranks), works out the answer to every
// accepted request and compares each returned answer with the oldest one
// still outstanding.
// ----------------------------------------------------------------------------
module union_find_rank_compress_checker
    import ufrc_pkg::*;
#(
    parameter int NODES = 128
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic [REQ_W-1:0]  s_req_type,
    input  logic [NODE_W-1:0] s_node_a,
    input  logic [NODE_W-1:0] s_node_b,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic              m_same_set,
    input  logic [NODE_W-1:0] m_root_of_a,
    output int                outstanding,
    output int                mismatches
);

    typedef struct packed {
        logic              same_set;
        logic [NODE_W-1:0] root_of_a;
    } answer_t;

    logic              root_flag [NODES];
    logic [NODE_W-1:0] up_link   [NODES];
    logic [RANK_W-1:0] tree_rank [NODES];

    answer_t answers_due [$];
    int      answer_count;
    int      fail_total;

    // walk to the root, then point every node on the way straight at it
    function automatic int find_and_flatten(input int node);
        int top;
        int walker;
        int nxt;
        int hops;
        top  = node;
        hops = 0;
        while (!root_flag[top] && hops < NODES) begin
            top = int'(up_link[top]) % NODES;
            hops++;
        end
        walker = node;
        hops   = 0;
        while (walker != top && !root_flag[walker] && hops < NODES) begin
            nxt             = int'(up_link[walker]) % NODES;
            up_link[walker] = NODE_W'(top);
            walker          = nxt;
            hops++;
        end
        return top;
    endfunction

    function automatic answer_t resolve_request(input logic [REQ_W-1:0]  kind,
                                                input logic [NODE_W-1:0] node_a,
                                                input logic [NODE_W-1:0] node_b);
        answer_t ans;
        int      ra;
        int      rb;
        logic    same;
        ans = '0;
        if (kind == REQ_CLEAR) begin
            for (int n = 0; n < NODES; n++) begin
                root_flag[n] = 1'b1;
                tree_rank[n] = '0;
            end
            return ans;
        end
        ra   = find_and_flatten(int'(node_a) % NODES);
        rb   = find_and_flatten(int'(node_b) % NODES);
        same = (ra == rb);
        if (kind == REQ_MERGE && !same) begin
            if (tree_rank[ra] < tree_rank[rb]) begin
                root_flag[ra] = 1'b0;
                up_link[ra]   = NODE_W'(rb);
                ra            = rb;
            end else if (tree_rank[rb] < tree_rank[ra]) begin
                root_flag[rb] = 1'b0;
                up_link[rb]   = NODE_W'(ra);
            end else begin
                // equal ranks: a's root goes under b's root
                root_flag[ra] = 1'b0;
                up_link[ra]   = NODE_W'(rb);
                if (tree_rank[rb] < RANK_MAX)
                    tree_rank[rb] = tree_rank[rb] + RANK_W'(1);
                ra = rb;
            end
        end
        ans.same_set  = same;
        ans.root_of_a = NODE_W'(ra);
        return ans;
    endfunction

    always @(posedge aclk) begin
        answer_t want;
        if (!aresetn) begin
            for (int n = 0; n < NODES; n++) begin
                root_flag[n] = 1'b1;
                up_link[n]   = '0;
                tree_rank[n] = '0;
            end
            answers_due.delete();
            answer_count = 0;
            fail_total   = 0;
        end else begin
            // retire first so a result never meets the answer queued this edge
            if (m_valid && m_ready) begin
                answer_count++;
                if (answers_due.size() == 0) begin
                    $display("%0t: result %0d with nothing outstanding: same_set %0b root_of_a %0d",
                             $time, answer_count, m_same_set, m_root_of_a);
                    fail_total++;
                end else begin
                    want = answers_due.pop_front();
                    if (m_same_set !== want.same_set) begin
                        $display("%0t: result %0d same_set expected %0b actual %0b",
                                 $time, answer_count, want.same_set, m_same_set);
                        fail_total++;
                    end
                    if (m_root_of_a !== want.root_of_a) begin
                        $display("%0t: result %0d root_of_a expected %0d actual %0d",
                                 $time, answer_count, want.root_of_a, m_root_of_a);
                        fail_total++;
                    end
                end
            end
            if (s_valid && s_ready)
                answers_due = {answers_due,
                               resolve_request(s_req_type, s_node_a, s_node_b)};
        end
        outstanding <= answers_due.size();
        mismatches  <= fail_total;
    end

endmodule

/* sim/union_find_rank_compress_core_test.sv */
// ----------------------------------------------------------------------------
// union_find_rank_compress_core_test
// Regression for the union-find engine. A short directed list covers the
// corner requests (clear, every merge rank case, same-set merge, the spare
// request code, extreme node indices); random traffic then grows forests by
// rank-balanced builds and local bursts, mixed with scattered and noisy
// requests, under three idling patterns on both channels.
// ----------------------------------------------------------------------------
module union_find_rank_compress_core_test
    import ufrc_pkg::*;
();

    localparam int NODES        = 128;
    localparam int RANDOM_ITEMS = 1850;
    // the limit allows for slow merges, clears and stalls on both sides over about
    // 1900 transactions, with a wide margin
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int TAIL_CYCLES  = 200;

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              s_valid     = 1'b0;
    logic              s_ready;
    logic [REQ_W-1:0]  s_req_type  = '0;
    logic [NODE_W-1:0] s_node_a    = '0;
    logic [NODE_W-1:0] s_node_b    = '0;
    logic              m_valid;
    logic              m_ready     = 1'b0;
    logic              m_same_set;
    logic [NODE_W-1:0] m_root_of_a;

    int outstanding;
    int mismatches;
    int tx_idle_pct = 38;
    int rx_idle_pct = 59;
    int accepted_items = 0;
    int cycle_count = 0;

    always #6 aclk = ~aclk;

    union_find_rank_compress_core #(
        .NODES (NODES)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_node_a    (s_node_a),
        .s_node_b    (s_node_b),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_same_set  (m_same_set),
        .m_root_of_a (m_root_of_a)
    );

    union_find_rank_compress_checker #(
        .NODES (NODES)
    ) u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_node_a    (s_node_a),
        .s_node_b    (s_node_b),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_same_set  (m_same_set),
        .m_root_of_a (m_root_of_a),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    // result side back-pressure, redrawn every cycle
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // watchdog: a hung engine or a lost result ends up here
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("union_find_rank_compress_core regression: fail");
            $finish;
        end
    end

    // one transaction on the request channel; valid stays up afterwards so that
    // back-to-back requests keep it high, and only a gap brings it down
    task automatic send_request(input logic [REQ_W-1:0]  kind,
                                input logic [NODE_W-1:0] node_a,
                                input logic [NODE_W-1:0] node_b);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_req_type <= kind;
        s_node_a   <= node_a;
        s_node_b   <= node_b;
        do @(posedge aclk); while (!s_ready);
        accepted_items++;
    endtask

    // one stretch of random traffic, mostly well-formed forest building
    task automatic random_sequence();
        int                pick;
        int                span;
        int                count;
        int                width;
        logic [NODE_W-1:0] base;
        logic [NODE_W-1:0] x;
        logic [NODE_W-1:0] y;
        logic [REQ_W-1:0]  kind;
        pick = $urandom_range(99);
        base = NODE_W'($urandom_range(NODES - 1));
        if (pick < 3) begin
            send_request(REQ_CLEAR, NODE_W'($urandom), NODE_W'($urandom));
        end else if (pick < 13) begin
            // rank-balanced build over a window: when a clear comes first, every merge is
            // a tie, so ranks climb to log2 of the window, up to the top rank
            span = 1 << $urandom_range(1, 7);
            if ($urandom_range(1))
                send_request(REQ_CLEAR, NODE_W'($urandom), NODE_W'($urandom));
            for (int s = 1; s < span; s = s * 2) begin
                for (int i = 0; i < span; i += 2 * s) begin
                    x = base + NODE_W'(i);
                    y = base + NODE_W'(i + s);
                    if ($urandom_range(1))
                        send_request(REQ_MERGE, x, y);
                    else
                        send_request(REQ_MERGE, y, x);
                end
            end
            count = $urandom_range(1, 4);
            for (int i = 0; i < count; i++)
                send_request(REQ_CHECK, base + NODE_W'($urandom_range(span - 1)),
                             NODE_W'($urandom));
        end else if (pick < 70) begin
            // dense burst in a small pool, so trees get deep and paths compress
            width = $urandom_range(3, 31);
            count = $urandom_range(4, 12);
            for (int i = 0; i < count; i++) begin
                x    = base + NODE_W'($urandom_range(width));
                y    = base + NODE_W'($urandom_range(width));
                span = $urandom_range(99);
                kind = (span < 60) ? REQ_MERGE : (span < 95) ? REQ_CHECK : REQ_SPARE;
                send_request(kind, x, y);
            end
        end else if (pick < 95) begin
            count = $urandom_range(1, 6);
            for (int i = 0; i < count; i++)
                send_request(REQ_W'($urandom_range(1, 3)), NODE_W'($urandom),
                             NODE_W'($urandom));
        end else begin
            // noise, clears included
            count = $urandom_range(1, 4);
            for (int i = 0; i < count; i++)
                send_request(REQ_W'($urandom_range(3)), NODE_W'($urandom),
                             NODE_W'($urandom));
        end
    endtask

    initial begin
        int directed_items;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed corners
        send_request(REQ_CHECK, 7'd0,   7'd127);  // fresh forest, apart
        send_request(REQ_MERGE, 7'd0,   7'd127);  // extremes, tie
        send_request(REQ_CHECK, 7'd127, 7'd0);
        send_request(REQ_MERGE, 7'd127, 7'd127);  // node with itself
        send_request(REQ_SPARE, 7'd0,   7'd127);  // spare code acts as a check
        send_request(REQ_MERGE, 7'd1,   7'd2);
        send_request(REQ_MERGE, 7'd3,   7'd4);
        send_request(REQ_MERGE, 7'd1,   7'd3);    // tie at rank one
        send_request(REQ_MERGE, 7'd5,   7'd1);    // a's root of lower rank
        send_request(REQ_MERGE, 7'd1,   7'd6);    // b's root of lower rank
        send_request(REQ_MERGE, 7'd2,   7'd4);    // already joined, compress only
        send_request(REQ_CHECK, 7'd4,   7'd5);
        send_request(REQ_MERGE, 7'd0,   7'd6);    // two trees of rank one and two
        send_request(REQ_CLEAR, 7'd127, 7'd127);  // clear with fields set
        send_request(REQ_CHECK, 7'd1,   7'd2);
        send_request(REQ_MERGE, 7'd126, 7'd1);
        send_request(REQ_SPARE, 7'd127, 7'd0);
        send_request(REQ_CLEAR, 7'd0,   7'd0);
        directed_items = accepted_items;

        // three idling patterns: receiver idling more, then swapped, then none
        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin
                tx_idle_pct = 59;
                rx_idle_pct = 38;
                // hold off until the engine has drained every answer
                s_valid <= 1'b0;
                do @(posedge aclk); while (outstanding != 0);
            end else if (ph == 2) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            while (accepted_items - directed_items < (ph + 1) * RANDOM_ITEMS / 3)
                random_sequence();
        end

        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("union_find_rank_compress_core regression: pass");
        else
            $display("union_find_rank_compress_core regression: fail");
        $finish;
    end

endmodule

/* sim.f */
src/ufrc_pkg.sv
src/ufrc_sequencer.sv
src/ufrc_datapath.sv
src/union_find_rank_compress_core.sv
sim/union_find_rank_compress_checker.sv
sim/union_find_rank_compress_core_test.sv
